@@ src/ffd_pkg.sv @@
// ffd_pkg: shared types, register codes and helpers for fractional_feedback_delay.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package ffd_pkg;

    localparam logic [1:0] CFG_DELAY_TARGET   = 2'd0;
    localparam logic [1:0] CFG_SMOOTHING_RATE = 2'd1;
    localparam logic [1:0] CFG_FEEDBACK_GAIN  = 2'd2;
    localparam logic [1:0] CFG_MIX_LEVEL      = 2'd3;

    localparam logic [15:0] RST_DELAY_TARGET   = 16'd0;
    localparam logic [15:0] RST_SMOOTHING_RATE = 16'd655;
    localparam logic [15:0] RST_FEEDBACK_GAIN  = 16'd16384;
    localparam logic [15:0] RST_MIX_LEVEL      = 16'd16384;

    localparam logic [16:0] ONE_Q15 = 17'd32768;

    typedef struct packed {
        logic clear;
        logic load;
        logic gmul;
        logic gupd;
        logic addr;
        logic rd0;
        logic rd1;
        logic interp;
        logic delay;
        logic mix;
        logic write;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic wi_last;
        logic out_free;
    } t_sts;

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/ffd_in_if.sv @@
// ffd_in_if: valid/ready channel carrying one dry input item.
// No dependencies.
`default_nettype none

interface ffd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

@@ src/ffd_out_if.sv @@
// ffd_out_if: valid/ready channel carrying one mixed output item.
// No dependencies.
`default_nettype none

interface ffd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

@@ src/fractional_feedback_delay.sv @@
// fractional_feedback_delay: feedback echo with a gliding, linearly interpolated delay.
// Depends on ffd_pkg, ffd_in_if, ffd_out_if, ffd_ctrl and ffd_dp.
//
//   channel    dir  handshake            payload
//   i_sample   in   valid/ready          sample_in  s16
//   o_sample   out  valid/ready          sample_out s16
//   i_cfg_*    in   i_cfg_we (no wait)   i_cfg_idx 2b, i_cfg_data 16b
//
// Each item passes through acceptance, glide multiply and update, address, two reads
// of the single ring read port, interpolation, rounding, mix multiply, write-back.
// After reset a clearing pass zeroes all RING_DEPTH ring entries, one entry a cycle;
// no item is taken during it, configuration writes are.
// A result waiting in the output register does not block the next item; the sequencer
// holds only when a new result is ready and the previous one is still not taken.
`default_nettype none

module fractional_feedback_delay import ffd_pkg::*; #(
    parameter int RING_DEPTH = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ffd_in_if.sink           i_sample,
    ffd_out_if.source        o_sample,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    ffd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (i_sample.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ffd_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample.sample_in),
        .o_out_valid  (o_sample.valid),
        .i_out_ready  (o_sample.ready),
        .o_sample_out (o_sample.sample_out)
    );

endmodule

`default_nettype wire

@@ src/ffd_ctrl.sv @@
// ffd_ctrl: sequencer for the clearing pass and the per-item steps.
// Depends on ffd_pkg (t_cmd, t_sts).
`default_nettype none

module ffd_ctrl import ffd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_GMUL,
        S_GUPD,
        S_ADDR,
        S_RD0,
        S_RD1,
        S_INTERP,
        S_DELAY,
        S_MIX,
        S_WRITE,
        S_PUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (i_sts.wi_last) n_state = S_IDLE;
            S_IDLE:   if (i_in_valid) n_state = S_GMUL;
            S_GMUL:   n_state = S_GUPD;
            S_GUPD:   n_state = S_ADDR;
            S_ADDR:   n_state = S_RD0;
            S_RD0:    n_state = S_RD1;
            S_RD1:    n_state = S_INTERP;
            S_INTERP: n_state = S_DELAY;
            S_DELAY:  n_state = S_MIX;
            S_MIX:    n_state = S_WRITE;
            S_WRITE:  n_state = i_sts.out_free ? S_IDLE : S_PUSH;
            S_PUSH:   if (i_sts.out_free) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.clear  = (r_state == S_CLEAR);
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.gmul   = (r_state == S_GMUL);
        o_cmd.gupd   = (r_state == S_GUPD);
        o_cmd.addr   = (r_state == S_ADDR);
        o_cmd.rd0    = (r_state == S_RD0);
        o_cmd.rd1    = (r_state == S_RD1);
        o_cmd.interp = (r_state == S_INTERP);
        o_cmd.delay  = (r_state == S_DELAY);
        o_cmd.mix    = (r_state == S_MIX);
        o_cmd.write  = (r_state == S_WRITE);
        o_cmd.push   = (r_state == S_PUSH) && i_sts.out_free;
    end

endmodule

`default_nettype wire

@@ src/ffd_dp.sv @@
// ffd_dp: config registers, glide, ring memory, interpolation, mix and output register.
// Depends on ffd_pkg; driven step by step by ffd_ctrl.
`default_nettype none

module ffd_dp import ffd_pkg::*; #(
    parameter int RING_DEPTH = 65536
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic signed [15:0] i_sample_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [15:0]      o_sample_out
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int SW = ((AW > 16) ? AW : 16) + 2;
    localparam logic [31:0] MAX_TGT =
        (RING_DEPTH - 1 > 65535) ? 32'd65535 : 32'(RING_DEPTH - 1);
    localparam logic [31:0] MAX_GLIDE = {MAX_TGT[15:0], 16'h0000};
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

    // configuration
    logic [15:0] r_delay_target;
    logic [15:0] r_rate;
    logic [15:0] r_fb;
    logic [15:0] r_mix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_target <= RST_DELAY_TARGET;
            r_rate         <= RST_SMOOTHING_RATE;
            r_fb           <= RST_FEEDBACK_GAIN;
            r_mix          <= RST_MIX_LEVEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DELAY_TARGET:   r_delay_target <= i_cfg_data;
                CFG_SMOOTHING_RATE: r_rate         <= i_cfg_data;
                CFG_FEEDBACK_GAIN:  r_fb           <= i_cfg_data;
                CFG_MIX_LEVEL:      r_mix          <= i_cfg_data;
                default:            r_mix          <= r_mix;
            endcase
        end
    end

    // control state
    logic [AW-1:0] r_wi;
    logic [31:0]   r_glide;
    logic          r_out_valid;

    // payload registers
    logic signed [15:0] r_x;
    logic [31:0]        r_gdist;
    logic               r_gup;
    logic [47:0]        r_gprod;
    logic [AW-1:0]      r_idx0;
    logic [AW-1:0]      r_idx1;
    logic [15:0]        r_frac;
    logic signed [15:0] r_a;
    logic signed [15:0] r_rdata;
    logic signed [33:0] r_iprod;
    logic signed [15:0] r_delayed;
    logic signed [33:0] r_pdry;
    logic signed [33:0] r_pwet;
    logic signed [33:0] r_pfb;
    logic signed [15:0] r_wet;
    logic signed [15:0] r_sample_out;
    logic signed [15:0] r_ring [RING_DEPTH];

    // glide distance
    logic [31:0] tgt32;
    logic [31:0] t16;
    logic        up;
    logic [47:0] gsum;
    logic [31:0] gstep;

    always_comb begin
        tgt32 = ({16'h0000, r_delay_target} > MAX_TGT) ? MAX_TGT
                                                       : {16'h0000, r_delay_target};
        t16   = {tgt32[15:0], 16'h0000};
        up    = (t16 >= r_glide);
        gsum  = r_gprod + 48'd32768;
        gstep = gsum[47:16];
    end

    // read position
    logic          borrow;
    logic [SW-1:0] base;
    logic [SW-1:0] wrapped;
    logic [AW-1:0] idx0;

    always_comb begin
        borrow  = (r_glide[15:0] != 16'h0000);
        base    = SW'(r_wi) - SW'(r_glide[31:16]) - SW'(borrow);
        wrapped = base[SW-1] ? (base + SW'(RING_DEPTH)) : base;
        idx0    = wrapped[AW-1:0];
    end

    // interpolation and mix arithmetic
    logic signed [16:0] diff;
    logic signed [34:0] isum;
    logic [16:0]        mixc;
    logic [16:0]        fbc;
    logic [16:0]        dryg;
    logic signed [34:0] wsum;
    logic signed [33:0] fsum;
    logic signed [19:0] stsum;
    logic signed [15:0] wet;
    logic signed [15:0] stored;

    always_comb begin
        diff  = {r_rdata[15], r_rdata} - {r_a[15], r_a};
        isum  = $signed({{3{r_a[15]}}, r_a, 16'h0000}) + $signed({r_iprod[33], r_iprod})
              + 35'sd32768;
        mixc  = ({1'b0, r_mix} > ONE_Q15) ? ONE_Q15 : {1'b0, r_mix};
        fbc   = ({1'b0, r_fb} > ONE_Q15) ? ONE_Q15 : {1'b0, r_fb};
        dryg  = ONE_Q15 - mixc;
        wsum  = $signed({r_pdry[33], r_pdry}) + $signed({r_pwet[33], r_pwet})
              + 35'sd16384;
        wet   = sat16(wsum[34:15]);
        fsum  = r_pfb + 34'sd16384;
        stsum = $signed({{4{r_x[15]}}, r_x}) + $signed({fsum[33], fsum[33:15]});
        stored = sat16(stsum);
    end

    // ring memory: one write port, one registered read port
    logic               mem_we;
    logic signed [15:0] mem_wdata;
    logic [AW-1:0]      raddr;

    assign mem_we    = i_cmd.clear || i_cmd.write;
    assign mem_wdata = i_cmd.clear ? 16'sh0000 : stored;
    assign raddr     = i_cmd.rd0 ? r_idx0 : r_idx1;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[r_wi] <= mem_wdata;
        end
        r_rdata <= r_ring[raddr];
    end

    logic load_out;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.wi_last  = (r_wi == LAST_IDX);
    assign load_out       = (i_cmd.write && o_sts.out_free) || i_cmd.push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi        <= '0;
            r_glide     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (mem_we) begin
                r_wi <= (r_wi == LAST_IDX) ? '0 : r_wi + 1'b1;
            end
            if (i_cmd.gupd) begin
                r_glide <= r_gup ? r_glide + gstep : r_glide - gstep;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= i_sample_in;
            r_gup   <= up;
            r_gdist <= up ? (t16 - r_glide) : (r_glide - t16);
        end
        if (i_cmd.gmul) begin
            r_gprod <= r_gdist * {32'h0, r_rate};
        end
        if (i_cmd.addr) begin
            r_idx0 <= idx0;
            r_idx1 <= (idx0 == LAST_IDX) ? '0 : idx0 + 1'b1;
            r_frac <= 16'(~r_glide[15:0] + 16'd1);
        end
        if (i_cmd.rd1) begin
            r_a <= r_rdata;
        end
        if (i_cmd.interp) begin
            r_iprod <= 34'(diff * $signed({1'b0, r_frac}));
        end
        if (i_cmd.delay) begin
            r_delayed <= isum[31:16];
        end
        if (i_cmd.mix) begin
            r_pdry <= $signed({1'b0, dryg}) * r_x;
            r_pwet <= $signed({1'b0, mixc}) * r_delayed;
            r_pfb  <= $signed({1'b0, fbc}) * r_delayed;
        end
        if (i_cmd.write) begin
            r_wet <= wet;
        end
        if (load_out) begin
            r_sample_out <= i_cmd.push ? r_wet : wet;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

    a_glide_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_glide <= MAX_GLIDE)
        else $error("glide delay beyond ring");

    a_idx_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.addr |=> (32'(r_idx0) < 32'(RING_DEPTH)) && (32'(r_idx1) < 32'(RING_DEPTH)))
        else $error("read index outside ring");

    a_out_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.write || i_cmd.push))
        else $error("output item without a finished step");

endmodule

`default_nettype wire

@@ bench/ffd_echo_checker.sv @@
// ffd_echo_checker: watches both sample channels and the config port of fractional_feedback_delay,
// predicts every mixed output item and compares it with what the block delivers.
// Depends on ffd_pkg, ffd_in_if and ffd_out_if.
module ffd_echo_checker import ffd_pkg::*; #(
    parameter int RING_DEPTH = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ffd_in_if                i_sample,
    ffd_out_if               o_sample,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    output int               o_pending,
    output int               o_fail_count
);

    logic signed [15:0] echo_ring [RING_DEPTH];
    longint             write_pos;
    logic [31:0]        glide;
    logic [15:0]        target_r;
    logic [15:0]        rate_r;
    logic [15:0]        fb_r;
    logic [15:0]        mix_r;

    logic signed [15:0] mix_due_q [$];
    int                 mismatches;

    function automatic longint rnd_shift(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end else if (v < -32768) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    // Glide, fractional read, mix and ring write-back for one dry item.
    function automatic logic signed [15:0] mix_next_sample(input logic signed [15:0] dry);
        longint x, one, tgt, fb, mix, rate, t16, g, total, pos, frac;
        longint idx0, idx1, a, b, delayed, wet, stored;
        x = dry;
        one = ONE_Q15;
        tgt = target_r;
        if (tgt > RING_DEPTH - 1) tgt = RING_DEPTH - 1;
        fb = fb_r;
        if (fb > one) fb = one;
        mix = mix_r;
        if (mix > one) mix = one;
        rate = rate_r;

        t16 = tgt <<< 16;
        g = glide;
        if (t16 >= g) begin
            g = g + (((t16 - g) * rate + 32768) >>> 16);
        end else begin
            g = g - (((g - t16) * rate + 32768) >>> 16);
        end
        glide = 32'(g);

        total = longint'(RING_DEPTH) <<< 16;
        pos = ((write_pos <<< 16) + total - (longint'(glide) % total)) % total;
        idx0 = pos >>> 16;
        frac = pos & 65535;
        idx1 = (idx0 + 1) % RING_DEPTH;
        a = echo_ring[idx0];
        b = echo_ring[idx1];
        delayed = rnd_shift((65536 - frac) * a + frac * b, 16);

        wet = rnd_shift((one - mix) * x + mix * delayed, 15);
        stored = x + rnd_shift(delayed * fb, 15);
        echo_ring[write_pos] = clip16(stored);
        write_pos = (write_pos + 1) % RING_DEPTH;
        return clip16(wet);
    endfunction

    task automatic report_error(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        logic signed [15:0] due;
        if (!i_rst_n) begin
            for (int k = 0; k < RING_DEPTH; k++) echo_ring[k] = '0;
            write_pos = 0;
            glide = '0;
            target_r = RST_DELAY_TARGET;
            rate_r = RST_SMOOTHING_RATE;
            fb_r = RST_FEEDBACK_GAIN;
            mix_r = RST_MIX_LEVEL;
            mix_due_q.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DELAY_TARGET:   target_r = i_cfg_data;
                    CFG_SMOOTHING_RATE: rate_r = i_cfg_data;
                    CFG_FEEDBACK_GAIN:  fb_r = i_cfg_data;
                    CFG_MIX_LEVEL:      mix_r = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_sample.valid && o_sample.ready) begin
                if (mix_due_q.size() == 0) begin
                    report_error($sformatf("unexpected sample_out %0d",
                                           o_sample.sample_out));
                end else begin
                    due = mix_due_q.pop_front();
                    if (o_sample.sample_out !== due) begin
                        report_error($sformatf("sample_out expected %0d got %0d",
                                               due, o_sample.sample_out));
                    end
                end
            end
            if (i_sample.valid && i_sample.ready) begin
                mix_due_q.push_back(mix_next_sample(i_sample.sample_in));
            end
        end
        o_pending <= mix_due_q.size();
        o_fail_count <= mismatches + mix_due_q.size();
    end

endmodule

@@ bench/fractional_feedback_delay_test.sv @@
// fractional_feedback_delay_test: drives reset, config writes and sample traffic with random
// gaps and stalls into fractional_feedback_delay and reports the verdict.
// Depends on ffd_pkg, ffd_in_if, ffd_out_if, fractional_feedback_delay and ffd_echo_checker.
module fractional_feedback_delay_test;
    import ffd_pkg::*;

    localparam int RING_DEPTH = 65536;
    localparam int STALL_LIMIT = 4 * RING_DEPTH;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    int pending_cnt;
    int fail_cnt;
    int idle_cycles = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    bit hold_req = 1'b0;

    ffd_in_if  in_ch ();
    ffd_out_if out_ch ();

    fractional_feedback_delay #(
        .RING_DEPTH (RING_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (in_ch),
        .o_sample   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    ffd_echo_checker #(
        .RING_DEPTH (RING_DEPTH)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (in_ch),
        .o_sample     (out_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending_cnt),
        .o_fail_count (fail_cnt)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [15:0] tgt, input logic [15:0] rate,
                                  input logic [15:0] fb, input logic [15:0] mix);
        put_reg(CFG_DELAY_TARGET, tgt);
        put_reg(CFG_SMOOTHING_RATE, rate);
        put_reg(CFG_FEEDBACK_GAIN, fb);
        put_reg(CFG_MIX_LEVEL, mix);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [15:0] x);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.sample_in <= x;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // drop valid, wait for every pending result, then let the write-back finish
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'($signed($urandom_range(0, 127)) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_target();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1, 2:    return 16'($urandom_range(0, 800));
            default: return 16'($urandom_range(0, 48));
        endcase
    endfunction

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hffff;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(300, 8000));
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // output side
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = rx_burst ? 0 : $urandom_range(0, 15);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        end
    end

    // input side and config
    initial begin
        in_ch.valid <= 1'b0;
        in_ch.sample_in <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_DELAY_TARGET;
        i_cfg_data <= '0;
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short delay, full feedback and full wet: ring and output saturate
        write_settings(16'd2, 16'hffff, 16'd32768, 16'd32768);
        repeat (4) send_sample(16'sh7fff);
        repeat (3) send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'sh0001);
        send_sample(16'shffff);
        settle();

        // longest delay, feedback gain above unity, dry only
        write_settings(16'hffff, 16'hffff, 16'hffff, 16'd0);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh5555);
        send_sample(16'shaaaa);
        settle();

        // glide back down through fractional positions
        write_settings(16'd1, 16'd30000, 16'd32769, 16'hffff);
        send_sample(16'sh7fff);
        send_sample(16'sh1234);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'shedcb);
        send_sample(16'sh4000);
        settle();

        // zero glide rate, no movement
        write_settings(16'd5, 16'd0, 16'd0, 16'd16384);
        repeat (5) send_sample(pick_sample());
        settle();

        for (int phase = 0; phase < 10; phase++) begin
            write_settings(pick_target(), pick_rate(), pick_gain(), pick_gain());
            tx_burst = (phase % 3 == 1);
            if (phase == 4) begin
                hold_req = 1'b1;
                tx_burst = 1'b1;
            end
            repeat (100) send_sample(pick_sample());
            settle();
        end

        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/ffd_pkg.sv
src/ffd_in_if.sv
src/ffd_out_if.sv
src/ffd_ctrl.sv
src/ffd_dp.sv
src/fractional_feedback_delay.sv
bench/ffd_echo_checker.sv
bench/fractional_feedback_delay_test.sv
